### src/bfie_pkg.sv
package bfie_pkg;

	// tape and loop stack geometry
	localparam int TAPE_CELLS = 32768;
	localparam int LOOP_DEPTH = 256;
	localparam int TAPE_AW    = $clog2(TAPE_CELLS);
	localparam int STACK_AW   = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;
	localparam int STACK_CW   = $clog2(LOOP_DEPTH + 1);

	// field widths fixed by the interface
	localparam int SYM_W  = 8;
	localparam int POS_W  = 16;
	localparam int CELL_W = 8;
	localparam int DEPTH_W = 16;
	localparam int STAT_W = 2;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// command symbols
	localparam logic [SYM_W-1:0] SYM_RIGHT = 8'h3E;
	localparam logic [SYM_W-1:0] SYM_LEFT  = 8'h3C;
	localparam logic [SYM_W-1:0] SYM_INC   = 8'h2B;
	localparam logic [SYM_W-1:0] SYM_DEC   = 8'h2D;
	localparam logic [SYM_W-1:0] SYM_IN    = 8'h2C;
	localparam logic [SYM_W-1:0] SYM_OUT   = 8'h2E;
	localparam logic [SYM_W-1:0] SYM_OPEN  = 8'h5B;
	localparam logic [SYM_W-1:0] SYM_CLOSE = 8'h5D;

	// status codes
	localparam logic [STAT_W-1:0] ST_RUNNING  = 2'd0;
	localparam logic [STAT_W-1:0] ST_UNMATCHED = 2'd1;
	localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;
	localparam logic [STAT_W-1:0] ST_HALTED   = 2'd3;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_RIGHT,
		OP_LEFT,
		OP_INC,
		OP_DEC,
		OP_IN,
		OP_OUT,
		OP_OPEN,
		OP_CLOSE
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [POS_W-1:0] next_position;
		logic [CELL_W-1:0] in_byte;
	} op_item_t;

	function automatic op_t classify(input logic [SYM_W-1:0] sym);
		op_t op;
		unique case (sym)
			SYM_RIGHT: op = OP_RIGHT;
			SYM_LEFT:  op = OP_LEFT;
			SYM_INC:   op = OP_INC;
			SYM_DEC:   op = OP_DEC;
			SYM_IN:    op = OP_IN;
			SYM_OUT:   op = OP_OUT;
			SYM_OPEN:  op = OP_OPEN;
			SYM_CLOSE: op = OP_CLOSE;
			default:   op = OP_NOP;
		endcase
		return op;
	endfunction

endpackage

### src/bfie_front.sv
module bfie_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          hold,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bfie_pkg::SYM_W-1:0]    symbol,
	input  logic [bfie_pkg::POS_W-1:0]    next_position,
	input  logic [bfie_pkg::CELL_W-1:0]   in_byte,
	output logic                          q_valid,
	input  logic                          q_pop,
	output bfie_pkg::op_item_t            q_item
);

	bfie_pkg::op_item_t                  entry_q [bfie_pkg::QUEUE_DEPTH];
	logic [bfie_pkg::QUEUE_AW-1:0]       wr_ptr_q;
	logic [bfie_pkg::QUEUE_AW-1:0]       rd_ptr_q;
	logic [bfie_pkg::QUEUE_CW-1:0]       count_q;
	logic                                push;
	logic                                pop;
	bfie_pkg::op_item_t                  new_item;

	assign in_ready = !hold && (count_q < bfie_pkg::QUEUE_CW'(bfie_pkg::QUEUE_DEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_item   = entry_q[rd_ptr_q];

	always_comb begin
		new_item.op            = bfie_pkg::classify(symbol);
		new_item.next_position = next_position;
		new_item.in_byte       = in_byte;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == bfie_pkg::QUEUE_AW'(bfie_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == bfie_pkg::QUEUE_AW'(bfie_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### src/bfie_back.sv
module bfie_back (
	input  logic                          clk,
	input  logic                          arst_n,
	output logic                          clearing,
	input  logic                          q_valid,
	output logic                          q_pop,
	input  bfie_pkg::op_item_t            q_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          emit_valid,
	output logic [bfie_pkg::CELL_W-1:0]   emit_byte,
	output logic                          jump_valid,
	output logic [bfie_pkg::POS_W-1:0]    jump_target,
	output logic [bfie_pkg::STAT_W-1:0]   status
);

	// tape memory with clearing sweep
	logic [bfie_pkg::CELL_W-1:0]   tape_mem [bfie_pkg::TAPE_CELLS];
	logic [bfie_pkg::CELL_W-1:0]   tape_rd_q;
	logic [bfie_pkg::CELL_W-1:0]   tape_fwd_q;
	logic                          tape_hit_q;
	logic                          t_we;
	logic [bfie_pkg::TAPE_AW-1:0]  t_wa;
	logic [bfie_pkg::CELL_W-1:0]   t_wd;
	logic [bfie_pkg::TAPE_AW-1:0]  clr_q;
	logic                          clearing_q;

	// loop stack memory
	logic [bfie_pkg::POS_W-1:0]    stack_mem [bfie_pkg::LOOP_DEPTH];
	logic [bfie_pkg::POS_W-1:0]    stack_rd_q;
	logic [bfie_pkg::POS_W-1:0]    stack_fwd_q;
	logic                          stack_hit_q;
	logic                          s_we;
	logic [bfie_pkg::STACK_AW-1:0] s_wa;
	logic [bfie_pkg::STACK_AW-1:0] s_ra;
	logic [bfie_pkg::STACK_CW-1:0] top_idx;

	// architectural state
	logic [bfie_pkg::TAPE_AW-1:0]  dp_q, dp_n;
	logic                          skip_q, skip_n;
	logic [bfie_pkg::DEPTH_W-1:0]  depth_q, depth_n;
	logic [bfie_pkg::STACK_CW-1:0] cnt_q, cnt_n;
	logic [bfie_pkg::STAT_W-1:0]   halt_q, halt_n;

	logic [bfie_pkg::CELL_W-1:0]   cur_cell;
	logic [bfie_pkg::POS_W-1:0]    top;
	logic                          fire;

	logic                          ev_n, jv_n;
	logic [bfie_pkg::CELL_W-1:0]   eb_n;
	logic [bfie_pkg::POS_W-1:0]    jt_n;
	logic [bfie_pkg::STAT_W-1:0]   st_n;

	logic                          out_valid_q;
	logic                          ev_q, jv_q;
	logic [bfie_pkg::CELL_W-1:0]   eb_q;
	logic [bfie_pkg::POS_W-1:0]    jt_q;
	logic [bfie_pkg::STAT_W-1:0]   st_q;

	assign clearing = clearing_q;
	assign fire     = q_valid && !clearing_q && (!out_valid_q || out_ready);
	assign q_pop    = fire;

	// current cell and stack top, with bypass of last cycle's write
	assign cur_cell = tape_hit_q  ? tape_fwd_q  : tape_rd_q;
	assign top      = stack_hit_q ? stack_fwd_q : stack_rd_q;

	assign top_idx = cnt_n - 1'b1;
	assign s_ra    = top_idx[bfie_pkg::STACK_AW-1:0];

	always_comb begin
		dp_n    = dp_q;
		skip_n  = skip_q;
		depth_n = depth_q;
		cnt_n   = cnt_q;
		halt_n  = halt_q;
		t_we    = 1'b0;
		t_wa    = dp_q;
		t_wd    = cur_cell;
		s_we    = 1'b0;
		s_wa    = cnt_q[bfie_pkg::STACK_AW-1:0];
		ev_n    = 1'b0;
		eb_n    = '0;
		jv_n    = 1'b0;
		jt_n    = '0;
		st_n    = bfie_pkg::ST_RUNNING;
		if (clearing_q) begin
			t_we = 1'b1;
			t_wa = clr_q;
			t_wd = '0;
		end else if (fire) begin
			if (halt_q != bfie_pkg::ST_RUNNING) begin
				st_n = bfie_pkg::ST_HALTED;
			end else if (skip_q) begin
				if (q_item.op == bfie_pkg::OP_OPEN) begin
					if (depth_q != '1) begin
						depth_n = depth_q + 1'b1;
					end
				end else if (q_item.op == bfie_pkg::OP_CLOSE) begin
					if (depth_q == '0) begin
						skip_n = 1'b0;
					end else begin
						depth_n = depth_q - 1'b1;
					end
				end
			end else begin
				unique case (q_item.op)
					bfie_pkg::OP_RIGHT: begin
						dp_n = (dp_q == bfie_pkg::TAPE_AW'(bfie_pkg::TAPE_CELLS - 1))
							? '0 : dp_q + 1'b1;
					end
					bfie_pkg::OP_LEFT: begin
						dp_n = (dp_q == '0)
							? bfie_pkg::TAPE_AW'(bfie_pkg::TAPE_CELLS - 1) : dp_q - 1'b1;
					end
					bfie_pkg::OP_INC: begin
						t_we = 1'b1;
						t_wd = cur_cell + 1'b1;
					end
					bfie_pkg::OP_DEC: begin
						t_we = 1'b1;
						t_wd = cur_cell - 1'b1;
					end
					bfie_pkg::OP_IN: begin
						t_we = 1'b1;
						t_wd = q_item.in_byte;
					end
					bfie_pkg::OP_OUT: begin
						ev_n = 1'b1;
						eb_n = cur_cell;
					end
					bfie_pkg::OP_OPEN: begin
						if (cur_cell == '0) begin
							skip_n  = 1'b1;
							depth_n = '0;
						end else if (cnt_q == bfie_pkg::STACK_CW'(bfie_pkg::LOOP_DEPTH)) begin
							halt_n = bfie_pkg::ST_OVERFLOW;
							st_n   = bfie_pkg::ST_OVERFLOW;
						end else begin
							s_we  = 1'b1;
							cnt_n = cnt_q + 1'b1;
						end
					end
					bfie_pkg::OP_CLOSE: begin
						if (cnt_q == '0) begin
							halt_n = bfie_pkg::ST_UNMATCHED;
							st_n   = bfie_pkg::ST_UNMATCHED;
						end else if (cur_cell != '0) begin
							jv_n = 1'b1;
							jt_n = top;
						end else begin
							cnt_n = cnt_q - 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// tape: one write and one registered read per cycle, read tracks next pointer
	always_ff @(posedge clk) begin
		if (t_we) begin
			tape_mem[t_wa] <= t_wd;
		end
		tape_rd_q  <= tape_mem[dp_n];
		tape_fwd_q <= t_wd;
		tape_hit_q <= t_we && (t_wa == dp_n);
	end

	// stack: read tracks the next top of stack
	always_ff @(posedge clk) begin
		if (s_we) begin
			stack_mem[s_wa] <= q_item.next_position;
		end
		stack_rd_q  <= stack_mem[s_ra];
		stack_fwd_q <= q_item.next_position;
		stack_hit_q <= s_we && (s_wa == s_ra);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
			dp_q       <= '0;
			skip_q     <= 1'b0;
			depth_q    <= '0;
			cnt_q      <= '0;
			halt_q     <= bfie_pkg::ST_RUNNING;
			out_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == bfie_pkg::TAPE_AW'(bfie_pkg::TAPE_CELLS - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			dp_q    <= dp_n;
			skip_q  <= skip_n;
			depth_q <= depth_n;
			cnt_q   <= cnt_n;
			halt_q  <= halt_n;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			ev_q <= ev_n;
			eb_q <= eb_n;
			jv_q <= jv_n;
			jt_q <= jt_n;
			st_q <= st_n;
		end
	end

	assign out_valid   = out_valid_q;
	assign emit_valid  = ev_q;
	assign emit_byte   = eb_q;
	assign jump_valid  = jv_q;
	assign jump_target = jt_q;
	assign status      = st_q;

endmodule

### src/brainfuck_instruction_executor_unit.sv
// an accepted item is queued by the front, then executed into the back's output register
// throughput: one item per cycle without output stalls, set by the tape read-modify-write
// in the back end, with the next cell read registered and the last write bypassed
// reset: asynchronous, active low; afterwards a clearing sweep zeroes the tape, one cell per
// cycle, over all TAPE_CELLS (32768) cells, during which no item is accepted
module brainfuck_instruction_executor_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bfie_pkg::SYM_W-1:0]    symbol,
	input  logic [bfie_pkg::POS_W-1:0]    next_position,
	input  logic [bfie_pkg::CELL_W-1:0]   in_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          emit_valid,
	output logic [bfie_pkg::CELL_W-1:0]   emit_byte,
	output logic                          jump_valid,
	output logic [bfie_pkg::POS_W-1:0]    jump_target,
	output logic [bfie_pkg::STAT_W-1:0]   status
);

	// front to back queue handshake
	logic               q_valid;
	logic               q_pop;
	bfie_pkg::op_item_t q_item;
	// back end busy sweeping the tape after reset
	logic               clearing;

	// front: takes each item, turns the symbol into an operation and queues it
	bfie_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.hold          (clearing),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.symbol        (symbol),
		.next_position (next_position),
		.in_byte       (in_byte),
		.q_valid       (q_valid),
		.q_pop         (q_pop),
		.q_item        (q_item)
	);

	// back: holds tape, pointer, skip state and loop stack, executes one operation
	// per cycle, unless the output stalls, into a registered result
	bfie_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.clearing    (clearing),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_item      (q_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.emit_valid  (emit_valid),
		.emit_byte   (emit_byte),
		.jump_valid  (jump_valid),
		.jump_target (jump_target),
		.status      (status)
	);

endmodule

### tb/brainfuck_instruction_executor_unit_tb.sv
`timescale 1ns / 100ps

module brainfuck_instruction_executor_unit_tb;

	// symbols sent in the random part
	localparam int RANDOM_ITEMS = 1100;
	// generous watchdog: clearing sweep plus the slowest legal run, several times over
	localparam int CYCLE_LIMIT = 1000000;
	// highest value the skip nesting counter can hold
	localparam int DEPTH_CEIL = (1 << bfie_pkg::DEPTH_W) - 1;

	// one result as seen on the output ports
	typedef struct packed {
		logic                          emit_valid;
		logic [bfie_pkg::CELL_W-1:0]   emit_byte;
		logic                          jump_valid;
		logic [bfie_pkg::POS_W-1:0]    jump_target;
		logic [bfie_pkg::STAT_W-1:0]   status;
	} exec_result_t;

	// executor shadow: tape, pointer, skip state and loop stack, plus the
	// queue of results that accepted items still owe
	class exec_scoreboard;
		logic [bfie_pkg::CELL_W-1:0]   tape [bfie_pkg::TAPE_CELLS];
		logic [bfie_pkg::TAPE_AW-1:0]  cell_ptr;
		bit                            skipping;
		logic [bfie_pkg::DEPTH_W-1:0]  skip_depth;
		logic [bfie_pkg::POS_W-1:0]    loop_starts [bfie_pkg::LOOP_DEPTH];
		int                            stack_used;
		logic [bfie_pkg::STAT_W-1:0]   halt_code;
		exec_result_t                  owed_results [$];
		int                            mismatches;
		int                            results_checked;
		int                            outputs_seen;
		int                            repeats_seen;
		int                            exits_seen;

		function new();
			foreach (tape[i])
				tape[i] = '0;
			cell_ptr = '0;
			skipping = 1'b0;
			skip_depth = '0;
			stack_used = 0;
			halt_code = bfie_pkg::ST_RUNNING;
			mismatches = 0;
			results_checked = 0;
			outputs_seen = 0;
			repeats_seen = 0;
			exits_seen = 0;
		endfunction

		static function bit is_command(logic [bfie_pkg::SYM_W-1:0] sym);
			return sym inside {bfie_pkg::SYM_RIGHT, bfie_pkg::SYM_LEFT, bfie_pkg::SYM_INC,
				bfie_pkg::SYM_DEC, bfie_pkg::SYM_IN, bfie_pkg::SYM_OUT,
				bfie_pkg::SYM_OPEN, bfie_pkg::SYM_CLOSE};
		endfunction

		// execute one accepted symbol and queue the result it owes
		function void note_input(logic [bfie_pkg::SYM_W-1:0] sym,
				logic [bfie_pkg::POS_W-1:0] npos, logic [bfie_pkg::CELL_W-1:0] ib);
			exec_result_t r;
			r = '0;
			if (halt_code != bfie_pkg::ST_RUNNING) begin
				r.status = bfie_pkg::ST_HALTED;
			end else if (is_command(sym) && skipping) begin
				// only brackets move the skip state
				if (sym == bfie_pkg::SYM_OPEN) begin
					if (skip_depth != bfie_pkg::DEPTH_W'(DEPTH_CEIL))
						skip_depth++;
				end else if (sym == bfie_pkg::SYM_CLOSE) begin
					if (skip_depth == '0)
						skipping = 1'b0;
					else
						skip_depth--;
				end
			end else if (is_command(sym)) begin
				case (sym)
					bfie_pkg::SYM_RIGHT: begin
						cell_ptr = (cell_ptr == bfie_pkg::TAPE_AW'(bfie_pkg::TAPE_CELLS - 1))
							? '0 : cell_ptr + 1'b1;
					end
					bfie_pkg::SYM_LEFT: begin
						cell_ptr = (cell_ptr == '0)
							? bfie_pkg::TAPE_AW'(bfie_pkg::TAPE_CELLS - 1) : cell_ptr - 1'b1;
					end
					bfie_pkg::SYM_INC: tape[cell_ptr] = tape[cell_ptr] + 1'b1;
					bfie_pkg::SYM_DEC: tape[cell_ptr] = tape[cell_ptr] - 1'b1;
					bfie_pkg::SYM_IN:  tape[cell_ptr] = ib;
					bfie_pkg::SYM_OUT: begin
						r.emit_valid = 1'b1;
						r.emit_byte = tape[cell_ptr];
						outputs_seen++;
					end
					bfie_pkg::SYM_OPEN: begin
						if (tape[cell_ptr] == '0) begin
							skipping = 1'b1;
							skip_depth = '0;
						end else if (stack_used >= bfie_pkg::LOOP_DEPTH) begin
							halt_code = bfie_pkg::ST_OVERFLOW;
							r.status = bfie_pkg::ST_OVERFLOW;
						end else begin
							loop_starts[stack_used] = npos;
							stack_used++;
						end
					end
					bfie_pkg::SYM_CLOSE: begin
						if (stack_used == 0) begin
							halt_code = bfie_pkg::ST_UNMATCHED;
							r.status = bfie_pkg::ST_UNMATCHED;
						end else if (tape[cell_ptr] != '0) begin
							r.jump_valid = 1'b1;
							r.jump_target = loop_starts[stack_used - 1];
							repeats_seen++;
						end else begin
							stack_used--;
							exits_seen++;
						end
					end
					default: ;
				endcase
			end
			owed_results.push_back(r);
		endfunction

		task report_mismatch(string what);
			$display("%0t mismatch: %s", $realtime, what);
			mismatches++;
		endtask

		task check_result(exec_result_t got);
			exec_result_t want;
			results_checked++;
			if (owed_results.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing owed",
					results_checked));
				return;
			end
			want = owed_results.pop_front();
			if (got.emit_valid !== want.emit_valid)
				report_mismatch($sformatf("result %0d emit_valid %b, want %b",
					results_checked, got.emit_valid, want.emit_valid));
			if (got.emit_byte !== want.emit_byte)
				report_mismatch($sformatf("result %0d emit_byte %h, want %h",
					results_checked, got.emit_byte, want.emit_byte));
			if (got.jump_valid !== want.jump_valid)
				report_mismatch($sformatf("result %0d jump_valid %b, want %b",
					results_checked, got.jump_valid, want.jump_valid));
			if (got.jump_target !== want.jump_target)
				report_mismatch($sformatf("result %0d jump_target %h, want %h",
					results_checked, got.jump_target, want.jump_target));
			if (got.status !== want.status)
				report_mismatch($sformatf("result %0d status %0d, want %0d",
					results_checked, got.status, want.status));
		endtask
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_ready;
	logic [bfie_pkg::SYM_W-1:0]     symbol;
	logic [bfie_pkg::POS_W-1:0]     next_position;
	logic [bfie_pkg::CELL_W-1:0]    in_byte;
	logic                           out_valid;
	logic                           out_ready;
	logic                           emit_valid;
	logic [bfie_pkg::CELL_W-1:0]    emit_byte;
	logic                           jump_valid;
	logic [bfie_pkg::POS_W-1:0]     jump_target;
	logic [bfie_pkg::STAT_W-1:0]    status;

	exec_scoreboard                 sb;
	exec_result_t                   rx_result;
	bit                             idle_on;
	int                             items_sent;
	int                             tx_calm_left;
	int                             rx_hold_left;
	int                             rx_stall_left;
	int                             rx_calm_left;
	logic [bfie_pkg::POS_W-1:0]     prog_pos;

	brainfuck_instruction_executor_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.symbol        (symbol),
		.next_position (next_position),
		.in_byte       (in_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.emit_valid    (emit_valid),
		.emit_byte     (emit_byte),
		.jump_valid    (jump_valid),
		.jump_target   (jump_target),
		.status        (status)
	);

	always #5 clk = ~clk;

	// program position that goes with the next symbol: mostly sequential,
	// now and then a jump somewhere else in the program
	function automatic logic [bfie_pkg::POS_W-1:0] next_pos();
		if ($urandom_range(0, 9) == 0)
			prog_pos = bfie_pkg::POS_W'($urandom);
		else
			prog_pos = prog_pos + 1'b1;
		return prog_pos;
	endfunction

	// offer one item, hold it until taken, then maybe leave a gap
	task automatic send_symbol(input logic [bfie_pkg::SYM_W-1:0] s,
			input logic [bfie_pkg::POS_W-1:0] p, input logic [bfie_pkg::CELL_W-1:0] b);
		int gap;
		in_valid <= 1'b1;
		symbol <= s;
		next_position <= p;
		in_byte <= b;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_input(s, p, b);
		items_sent++;
		if (tx_calm_left > 0) begin
			tx_calm_left--;
		end else if (idle_on && $urandom_range(0, 3) == 0) begin
			// idle burst, then a stretch of back-to-back items
			gap = $urandom_range(1, 11);
			tx_calm_left = $urandom_range(0, 30);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// get out of any skip and unwind the loop stack with zero-cell closes
	task automatic leave_loops();
		while (sb.skipping)
			send_symbol(bfie_pkg::SYM_CLOSE, next_pos(), bfie_pkg::CELL_W'($urandom));
		while (sb.stack_used > 0) begin
			if (sb.tape[sb.cell_ptr] != '0)
				send_symbol(bfie_pkg::SYM_IN, next_pos(), '0);
			send_symbol(bfie_pkg::SYM_CLOSE, next_pos(), bfie_pkg::CELL_W'($urandom));
		end
	endtask

	// short hand-written program over the edges of every command
	task automatic run_directed();
		send_symbol(bfie_pkg::SYM_OUT, 16'h0000, 8'h00);     // fresh tape reads zero
		send_symbol(bfie_pkg::SYM_LEFT, 16'h0001, 8'hFF);    // pointer wraps down to the top cell
		send_symbol(bfie_pkg::SYM_DEC, 16'h0002, 8'h00);     // cell wraps to 255
		send_symbol(bfie_pkg::SYM_OUT, 16'h0003, 8'h00);
		send_symbol(bfie_pkg::SYM_INC, 16'h0004, 8'h00);     // and back up to zero
		send_symbol(bfie_pkg::SYM_RIGHT, 16'h0005, 8'h00);   // pointer wraps up to cell zero
		send_symbol(bfie_pkg::SYM_IN, 16'h0006, 8'hFF);
		send_symbol(bfie_pkg::SYM_OUT, 16'h0007, 8'h00);
		send_symbol(bfie_pkg::SYM_IN, 16'h0008, 8'h00);
		// open on a zero cell skips the whole nested loop body
		send_symbol(bfie_pkg::SYM_OPEN, 16'h0009, 8'h00);
		send_symbol(bfie_pkg::SYM_OPEN, 16'h000A, 8'h00);
		send_symbol(bfie_pkg::SYM_INC, 16'h000B, 8'h00);
		send_symbol(bfie_pkg::SYM_OUT, 16'h000C, 8'h00);
		send_symbol(bfie_pkg::SYM_CLOSE, 16'h000D, 8'h00);
		send_symbol(bfie_pkg::SYM_CLOSE, 16'h000E, 8'h00);
		// one pass of a real loop: repeat on nonzero, exit on zero
		send_symbol(bfie_pkg::SYM_IN, 16'h000F, 8'h01);
		send_symbol(bfie_pkg::SYM_OPEN, 16'hFFFF, 8'h00);
		send_symbol(bfie_pkg::SYM_CLOSE, 16'h0000, 8'h00);
		send_symbol(bfie_pkg::SYM_DEC, 16'h0001, 8'h00);
		send_symbol(bfie_pkg::SYM_CLOSE, 16'h0002, 8'h00);
		send_symbol(bfie_pkg::SYM_OUT, 16'h0003, 8'h00);
		// control bytes, high bytes and printable non-commands are ignored
		send_symbol(8'h00, 16'h0004, 8'h00);
		send_symbol(8'h1F, 16'h0005, 8'hFF);
		send_symbol(8'h7F, 16'h0006, 8'h00);
		send_symbol(8'hFF, 16'h0007, 8'hFF);
		send_symbol(8'h20, 16'h0008, 8'h00);
		send_symbol(8'h7E, 16'h0009, 8'hFF);
	endtask

	// random programs, kept clear of the two halting errors
	task automatic run_random();
		int sent;
		int roll;
		logic [bfie_pkg::SYM_W-1:0]  s;
		logic [bfie_pkg::CELL_W-1:0] b;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < 5) begin
				s = $urandom_range(0, 1) ? bfie_pkg::SYM_W'($urandom_range(0, 31))
					: bfie_pkg::SYM_W'($urandom_range(127, 255));
			end else if (roll < 10) begin
				do
					s = bfie_pkg::SYM_W'($urandom_range(8'h20, 8'h7E));
				while (exec_scoreboard::is_command(s));
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 22)
					s = bfie_pkg::SYM_INC;
				else if (roll < 30)
					s = bfie_pkg::SYM_DEC;
				else if (roll < 40)
					s = bfie_pkg::SYM_RIGHT;
				else if (roll < 50)
					s = bfie_pkg::SYM_LEFT;
				else if (roll < 58)
					s = bfie_pkg::SYM_IN;
				else if (roll < 68)
					s = bfie_pkg::SYM_OUT;
				else if (roll < 84)
					s = bfie_pkg::SYM_OPEN;
				else
					s = bfie_pkg::SYM_CLOSE;
			end
			// a close with nothing open would halt for good
			if (!sb.skipping && s == bfie_pkg::SYM_CLOSE && sb.stack_used == 0)
				s = bfie_pkg::SYM_OPEN;
			// so would one more push on a full stack
			if (!sb.skipping && s == bfie_pkg::SYM_OPEN
					&& sb.stack_used >= bfie_pkg::LOOP_DEPTH - 1)
				s = bfie_pkg::SYM_CLOSE;
			// lean toward closing so skips do not run on forever
			if (sb.skipping && s == bfie_pkg::SYM_OPEN && $urandom_range(0, 1) == 1)
				s = bfie_pkg::SYM_CLOSE;
			roll = $urandom_range(0, 99);
			b = (roll < 25) ? 8'h00 : (roll < 35) ? 8'hFF : bfie_pkg::CELL_W'($urandom);
			sent++;
			send_symbol(s, next_pos(), b);
		end
	endtask

	// a deeply nested skip, closed level by level, then normal work again
	task automatic run_deep_skip();
		while (sb.skipping)
			send_symbol(bfie_pkg::SYM_CLOSE, next_pos(), bfie_pkg::CELL_W'($urandom));
		if (sb.tape[sb.cell_ptr] != '0)
			send_symbol(bfie_pkg::SYM_IN, next_pos(), '0);
		send_symbol(bfie_pkg::SYM_OPEN, next_pos(), bfie_pkg::CELL_W'($urandom));
		repeat (12)
			send_symbol(bfie_pkg::SYM_OPEN, next_pos(), bfie_pkg::CELL_W'($urandom));
		repeat (13)
			send_symbol(bfie_pkg::SYM_CLOSE, next_pos(), bfie_pkg::CELL_W'($urandom));
		send_symbol(bfie_pkg::SYM_INC, next_pos(), bfie_pkg::CELL_W'($urandom));
		send_symbol(bfie_pkg::SYM_OUT, next_pos(), bfie_pkg::CELL_W'($urandom));
	endtask

	// end the program with one of the two errors, then show it stays halted
	task automatic run_halt();
		if ($urandom_range(0, 1) == 0) begin
			leave_loops();
			send_symbol(bfie_pkg::SYM_CLOSE, next_pos(), bfie_pkg::CELL_W'($urandom));
		end else begin
			while (sb.skipping)
				send_symbol(bfie_pkg::SYM_CLOSE, next_pos(), bfie_pkg::CELL_W'($urandom));
			send_symbol(bfie_pkg::SYM_IN, next_pos(), 8'h01);
			while (sb.halt_code == bfie_pkg::ST_RUNNING)
				send_symbol(bfie_pkg::SYM_OPEN, next_pos(), bfie_pkg::CELL_W'($urandom));
		end
		repeat (16)
			send_symbol(bfie_pkg::SYM_W'($urandom), next_pos(), bfie_pkg::CELL_W'($urandom));
		send_symbol(bfie_pkg::SYM_OUT, next_pos(), 8'h00);
		send_symbol(bfie_pkg::SYM_CLOSE, next_pos(), 8'h00);
	endtask

	// receiver: check every result taken, stall in random bursts, and twice
	// hold off long enough for the block to back up into its input
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			rx_result.emit_valid = emit_valid;
			rx_result.emit_byte = emit_byte;
			rx_result.jump_valid = jump_valid;
			rx_result.jump_target = jump_target;
			rx_result.status = status;
			sb.check_result(rx_result);
			if (idle_on && (sb.results_checked == 300 || sb.results_checked == 900))
				rx_hold_left = 200;
		end
		if (rx_hold_left > 0) begin
			out_ready <= 1'b0;
			rx_hold_left--;
		end else if (rx_stall_left > 0) begin
			out_ready <= 1'b0;
			rx_stall_left--;
		end else if (idle_on && rx_calm_left == 0 && $urandom_range(0, 3) == 0) begin
			// start a stall burst of random length, then a calm stretch
			out_ready <= 1'b0;
			rx_stall_left = $urandom_range(0, 10);
			rx_calm_left = $urandom_range(0, 40);
		end else begin
			out_ready <= 1'b1;
			if (rx_calm_left > 0)
				rx_calm_left--;
		end
	end

	// watchdog
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("brainfuck_instruction_executor_unit_tb: done, errors");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		symbol = '0;
		next_position = '0;
		in_byte = '0;
		out_ready = 1'b0;
		idle_on = 1'b1;
		items_sent = 0;
		tx_calm_left = 0;
		rx_hold_left = 0;
		rx_stall_left = 0;
		rx_calm_left = 0;
		prog_pos = bfie_pkg::POS_W'($urandom);
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// the block sits out its tape clearing sweep behind in_ready
		run_directed();
		run_random();

		// last part runs flat out on both sides
		idle_on = 1'b0;
		run_deep_skip();
		run_halt();
		in_valid <= 1'b0;

		while (sb.owed_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d items over %0d results: %0d bytes out, %0d loop repeats, %0d loop exits",
			items_sent, sb.results_checked, sb.outputs_seen, sb.repeats_seen, sb.exits_seen);
		$display("deep nested skip walked out; program ended on error status %0d",
			sb.halt_code);
		if (sb.mismatches == 0)
			$display("brainfuck_instruction_executor_unit_tb: done, clean");
		else
			$display("brainfuck_instruction_executor_unit_tb: done, errors");
		$finish;
	end

endmodule

### brainfuck_instruction_executor_unit.f
src/bfie_pkg.sv
src/bfie_front.sv
src/bfie_back.sv
src/brainfuck_instruction_executor_unit.sv
tb/brainfuck_instruction_executor_unit_tb.sv
